@@ src/interpolated_alpha_block_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the interpolated alpha block decoder
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_ALPHA_BLOCK_DECODER_MACROS_SVH
`define INTERPOLATED_ALPHA_BLOCK_DECODER_MACROS_SVH

// checked only outside reset
`define IABD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define IABD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/iabd_pkg.sv @@
// ----------------------------------------------------------------------------
// iabd_pkg
// Shared types, constants and helpers of the alpha block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iabd_pkg;

  localparam int EP_W        = 8;
  localparam int IDX_W       = 48;
  localparam int SEL_W       = 3;
  localparam int PIXELS      = 16;
  localparam int PIX_W       = $clog2(PIXELS);
  localparam int SUM_W       = 11;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 15;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // floor(x/7) = (x*4682)>>15 and floor(x/5) = (x*6554)>>15 for x < 2048
  localparam logic [RECIP_W-1:0] RECIP7 = RECIP_W'(4682);
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'(6554);

  localparam logic [EP_W-1:0] ALPHA_ZERO = '0;
  localparam logic [EP_W-1:0] ALPHA_FULL = '1;

  typedef struct packed {
    logic             interp7;
    logic [EP_W-1:0]  ep0;
    logic [EP_W-1:0]  ep1;
    logic [IDX_W-1:0] idx;
  } block_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    KIND_EP0,
    KIND_EP1,
    KIND_ZERO,
    KIND_FULL,
    KIND_DIV7,
    KIND_DIV5
  } kind_t;

  typedef struct packed {
    logic [SEL_W-1:0] w0;
    logic [SEL_W-1:0] w1;
  } weights_t;

  // weights of endpoint 0 and endpoint 1 for table entries 2 and up
  function automatic weights_t interp_weights(input logic [SEL_W-1:0] sel,
                                              input logic interp7);
    weights_t w;
    w.w1 = SEL_W'(sel - SEL_W'(1));
    if (interp7) begin
      w.w0 = SEL_W'(4'd8 - {1'b0, sel});
    end else begin
      w.w0 = SEL_W'(4'd6 - {1'b0, sel});
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/iabd_front.sv @@
// ----------------------------------------------------------------------------
// iabd_front
// Takes a compressed block on start and classifies its table mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iabd_front (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [iabd_pkg::EP_W-1:0]     endpoint_first,
  input  wire logic [iabd_pkg::EP_W-1:0]     endpoint_second,
  input  wire logic [iabd_pkg::IDX_W-1:0]    index_bits,
  input  wire iabd_pkg::q_status_t           q_status,
  output logic                               push,
  output iabd_pkg::block_t                   push_word
);

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  always_comb begin
    push_word.interp7 = endpoint_first > endpoint_second;
    push_word.ep0     = endpoint_first;
    push_word.ep1     = endpoint_second;
    push_word.idx     = index_bits;
  end

endmodule

`default_nettype wire

@@ src/iabd_queue.sv @@
// ----------------------------------------------------------------------------
// iabd_queue
// Two-entry block queue between the front and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iabd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire iabd_pkg::block_t     push_word,
  input  wire logic                 pop,
  output iabd_pkg::block_t          head,
  output iabd_pkg::q_status_t       q_status
);

  iabd_pkg::block_t                     mem [iabd_pkg::Q_DEPTH];
  logic [iabd_pkg::Q_PTR_W-1:0]         wr_ptr;
  logic [iabd_pkg::Q_PTR_W-1:0]         rd_ptr;
  logic [iabd_pkg::Q_CNT_W-1:0]         count;
  logic                                 do_push;
  logic                                 do_pop;

  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;

  assign q_status.full  = count == iabd_pkg::Q_CNT_W'(iabd_pkg::Q_DEPTH);
  assign q_status.empty = count == '0;
  assign head           = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= iabd_pkg::Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= iabd_pkg::Q_PTR_W'(rd_ptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= iabd_pkg::Q_CNT_W'(count + 1'b1);
        2'b01:   count <= iabd_pkg::Q_CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/iabd_back.sv @@
// ----------------------------------------------------------------------------
// iabd_back
// Walks the sixteen pixels of the head block and interpolates each alpha.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iabd_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire iabd_pkg::block_t             head,
  input  wire iabd_pkg::q_status_t          q_status,
  output logic                              pop,
  output logic                              strobe,
  output logic [iabd_pkg::PIX_W-1:0]        pixel_number,
  output logic [iabd_pkg::EP_W-1:0]         alpha_value,
  output logic                              last_pixel
);

  logic [iabd_pkg::PIX_W-1:0]    pix;
  logic                          issue;
  logic                          issue_last;
  logic [iabd_pkg::SEL_W-1:0]    sel;
  iabd_pkg::weights_t            w;
  iabd_pkg::kind_t               kind_next;
  logic [iabd_pkg::SUM_W-1:0]    sum_next;

  // stage one: table entry select and weighted sum
  logic                          s_valid;
  logic [iabd_pkg::PIX_W-1:0]    s_pix;
  logic                          s_last;
  iabd_pkg::kind_t               s_kind;
  logic [iabd_pkg::SUM_W-1:0]    s_sum;
  logic [iabd_pkg::EP_W-1:0]     s_ep0;
  logic [iabd_pkg::EP_W-1:0]     s_ep1;

  logic [iabd_pkg::RECIP_W-1:0]  recip;
  logic [iabd_pkg::PROD_W-1:0]   prod;
  logic [iabd_pkg::EP_W-1:0]     alpha_next;

  assign issue      = !q_status.empty;
  assign issue_last = pix == iabd_pkg::PIX_W'(iabd_pkg::PIXELS - 1);
  assign pop        = issue && issue_last;

  always_comb begin
    sel = head.idx[iabd_pkg::SEL_W * pix +: iabd_pkg::SEL_W];
    w   = iabd_pkg::interp_weights(sel, head.interp7);
    sum_next = iabd_pkg::SUM_W'(iabd_pkg::SUM_W'(w.w0) * iabd_pkg::SUM_W'(head.ep0))
             + iabd_pkg::SUM_W'(iabd_pkg::SUM_W'(w.w1) * iabd_pkg::SUM_W'(head.ep1));
    priority if (sel == iabd_pkg::SEL_W'(0)) begin
      kind_next = iabd_pkg::KIND_EP0;
    end else if (sel == iabd_pkg::SEL_W'(1)) begin
      kind_next = iabd_pkg::KIND_EP1;
    end else if (head.interp7) begin
      kind_next = iabd_pkg::KIND_DIV7;
    end else if (sel == iabd_pkg::SEL_W'(6)) begin
      kind_next = iabd_pkg::KIND_ZERO;
    end else if (sel == iabd_pkg::SEL_W'(7)) begin
      kind_next = iabd_pkg::KIND_FULL;
    end else begin
      kind_next = iabd_pkg::KIND_DIV5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix     <= '0;
      s_valid <= 1'b0;
    end else begin
      s_valid <= issue;
      if (issue) begin
        pix <= iabd_pkg::PIX_W'(pix + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s_pix  <= pix;
    s_last <= issue_last;
    s_kind <= kind_next;
    s_sum  <= sum_next;
    s_ep0  <= head.ep0;
    s_ep1  <= head.ep1;
  end

  // stage two: pick the alpha, dividing by five or seven through a reciprocal multiply
  always_comb begin
    recip = (s_kind == iabd_pkg::KIND_DIV7) ? iabd_pkg::RECIP7 : iabd_pkg::RECIP5;
    prod  = iabd_pkg::PROD_W'(s_sum) * iabd_pkg::PROD_W'(recip);
    unique case (s_kind)
      iabd_pkg::KIND_EP0:  alpha_next = s_ep0;
      iabd_pkg::KIND_EP1:  alpha_next = s_ep1;
      iabd_pkg::KIND_ZERO: alpha_next = iabd_pkg::ALPHA_ZERO;
      iabd_pkg::KIND_FULL: alpha_next = iabd_pkg::ALPHA_FULL;
      iabd_pkg::KIND_DIV7,
      iabd_pkg::KIND_DIV5: alpha_next = prod[iabd_pkg::RECIP_SHIFT +: iabd_pkg::EP_W];
      default:             alpha_next = iabd_pkg::ALPHA_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_number <= s_pix;
    alpha_value  <= alpha_next;
    last_pixel   <= s_last;
  end

endmodule

`default_nettype wire

@@ src/interpolated_alpha_block_decoder.sv @@
// A block's first pixel word strobes after the queue, stage one and output registers.
// Throughput: 16 pixel words per block on consecutive cycles, one pixel per cycle from
// the pixel sequencer while the queue holds a block.
// A two-block queue lets start be taken while the back end still emits earlier pixels.
// Reset (rst, synchronous): empties the queue, rewinds the pixel counter, drops strobe.
// ----------------------------------------------------------------------------
// interpolated_alpha_block_decoder
// Block alpha decoder: queue of compressed blocks feeding a pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interpolated_alpha_block_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [iabd_pkg::EP_W-1:0]     endpoint_first,
  input  wire logic [iabd_pkg::EP_W-1:0]     endpoint_second,
  input  wire logic [iabd_pkg::IDX_W-1:0]    index_bits,
  output logic                               strobe,
  output logic [iabd_pkg::PIX_W-1:0]         pixel_number,
  output logic [iabd_pkg::EP_W-1:0]          alpha_value,
  output logic                               last_pixel
);

  iabd_pkg::q_status_t  q_status;
  iabd_pkg::block_t     push_word;
  iabd_pkg::block_t     head;
  logic                 push;
  logic                 pop;

  iabd_front u_front (
    .start           (start),
    .busy            (busy),
    .endpoint_first  (endpoint_first),
    .endpoint_second (endpoint_second),
    .index_bits      (index_bits),
    .q_status        (q_status),
    .push            (push),
    .push_word       (push_word)
  );

  iabd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  iabd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .strobe       (strobe),
    .pixel_number (pixel_number),
    .alpha_value  (alpha_value),
    .last_pixel   (last_pixel)
  );

endmodule

`default_nettype wire

@@ src/iabd_checker.sv @@
// ----------------------------------------------------------------------------
// iabd_checker
// Port-level checks on the pixel word sequence of the alpha block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "interpolated_alpha_block_decoder_macros.svh"

module iabd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         strobe,
  input wire logic [iabd_pkg::PIX_W-1:0]   pixel_number,
  input wire logic                         last_pixel
);

  localparam logic [iabd_pkg::PIX_W-1:0] LAST_PIX = iabd_pkg::PIX_W'(iabd_pkg::PIXELS - 1);

  `IABD_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !strobe, "strobe after reset")
  `IABD_ASSERT(a_last_flag, clk, rst, strobe |-> (last_pixel == (pixel_number == LAST_PIX)), "last_pixel mismatch")
  `IABD_ASSERT(a_pixel_run, clk, rst, strobe && !last_pixel |=> strobe && (pixel_number == iabd_pkg::PIX_W'($past(pixel_number) + 1'b1)), "broken pixel run")
  `IABD_ASSERT(a_block_start, clk, rst, !strobe ##1 strobe |-> pixel_number == '0, "block not started at pixel 0")
  `IABD_ASSERT(a_accept_strobe, clk, rst, start && !busy |-> ##3 strobe, "no pixel word after accept")

endmodule

bind interpolated_alpha_block_decoder iabd_checker u_iabd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .pixel_number (pixel_number),
  .last_pixel   (last_pixel)
);

`default_nettype wire
